### sv/lttl_pkg.sv
package lttl_pkg;

    localparam int KEY_W = 51;
    localparam int CNT_W = 8;
    localparam int TOT_W = 48;
    localparam int TTL_W = 20;

    localparam logic [TTL_W-1:0] TTL_RESET = 20'd1800;
    localparam logic [CNT_W-1:0] MAX_RESET = 8'd100;

    localparam logic REG_TTL = 1'b0;
    localparam logic REG_MAX = 1'b1;

    typedef enum logic [1:0] {
        CMD_GET   = 2'd0,
        CMD_PUT   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_STATS = 2'd3
    } cmd_t;

    typedef struct packed {
        logic load;
        logic trim;
        logic look;
        logic read;
        logic exec;
    } ctl_t;

endpackage

### sv/lttl_ifs.sv
interface lttl_req_if;
    logic                valid;
    logic                ready;
    lttl_pkg::cmd_t      cmd;
    logic [31:0]         now_sec;
    logic signed [20:0]  latitude_q;
    logic signed [21:0]  longitude_q;
    logic [3:0]          forecast_kind;
    logic [3:0]          day_offset;
    logic [31:0]         value_handle;

    modport source (
        output valid, cmd, now_sec, latitude_q, longitude_q, forecast_kind,
               day_offset, value_handle,
        input  ready
    );
    modport sink (
        input  valid, cmd, now_sec, latitude_q, longitude_q, forecast_kind,
               day_offset, value_handle,
        output ready
    );
endinterface

interface lttl_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic [31:0]                   value_out;
    logic [lttl_pkg::TOT_W-1:0]    hit_total;
    logic [lttl_pkg::TOT_W-1:0]    miss_total;
    logic [lttl_pkg::CNT_W-1:0]    entry_count;

    modport source (
        output valid, hit, value_out, hit_total, miss_total, entry_count,
        input  ready
    );
    modport sink (
        input  valid, hit, value_out, hit_total, miss_total, entry_count,
        output ready
    );
endinterface

### sv/lttl_ctrl.sv
module lttl_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  logic           trim_req,
    output lttl_pkg::ctl_t ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TRIM,
        S_LOOK,
        S_READ,
        S_EXEC
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   out_busy;

    assign out_busy  = out_valid_reg && !out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        ctl      = '0;
        ctl.load = (state_reg == S_IDLE) && in_valid;
        ctl.trim = (state_reg == S_TRIM) || trim_req;
        ctl.look = (state_reg == S_LOOK);
        ctl.read = (state_reg == S_READ);
        ctl.exec = (state_reg == S_EXEC) && !out_busy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == S_EXEC) && !out_busy)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_TRIM;
                    end
                end
                S_TRIM: state_reg <= S_LOOK;
                S_LOOK: state_reg <= S_READ;
                S_READ: state_reg <= S_EXEC;
                S_EXEC:
                begin
                    if (!out_busy)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_accept_to_trim: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_TRIM))
        else $error("accepted transfer did not start trim");
    a_no_exec_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.exec |-> !(out_valid_reg && !out_ready))
        else $error("update while result stalled");
`endif

endmodule

### sv/lttl_dp.sv
module lttl_dp #(
    parameter int DEPTH = 128
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lttl_pkg::ctl_t              ctl,
    input  lttl_pkg::cmd_t              cmd,
    input  logic [31:0]                 now_sec,
    input  logic [lttl_pkg::KEY_W-1:0]  key,
    input  logic [31:0]                 handle,
    input  logic [lttl_pkg::TTL_W-1:0]  ttl,
    input  logic [lttl_pkg::CNT_W-1:0]  limit,
    output logic                        hit,
    output logic [31:0]                 value_out,
    output logic [lttl_pkg::TOT_W-1:0]  hit_total,
    output logic [lttl_pkg::TOT_W-1:0]  miss_total,
    output logic [lttl_pkg::CNT_W-1:0]  entry_count
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = ((IW > lttl_pkg::CNT_W) ? IW : lttl_pkg::CNT_W) + 1;
    localparam logic [lttl_pkg::TOT_W-1:0] TOT_MAX = '1;

    lttl_pkg::cmd_t              cmd_reg;
    logic [31:0]                 now_reg;
    logic [lttl_pkg::KEY_W-1:0]  key_reg;
    logic [31:0]                 handle_reg;

    logic [DEPTH-1:0]            valid_reg;
    logic [IW-1:0]               rank_reg [DEPTH];
    logic [lttl_pkg::KEY_W-1:0]  key_cell_reg [DEPTH];
    logic [31:0]                 value_mem [DEPTH];
    logic [31:0]                 expiry_mem [DEPTH];

    logic [lttl_pkg::CNT_W-1:0]  entries_reg;
    logic [lttl_pkg::TOT_W-1:0]  hits_reg;
    logic [lttl_pkg::TOT_W-1:0]  misses_reg;

    logic [DEPTH-1:0]            match_vec_reg;
    logic                        match_any_reg;
    logic [IW-1:0]               match_idx_reg;

    logic [IW-1:0]               rank_m_reg;
    logic [DEPTH-1:0]            evict_vec_reg;
    logic [IW-1:0]               ins_idx_reg;
    logic                        full_reg;
    logic [31:0]                 value_rd_reg;
    logic [31:0]                 expiry_rd_reg;

    logic                        hit_reg;
    logic [31:0]                 value_out_reg;
    logic [lttl_pkg::CNT_W-1:0]  count_out_reg;

    logic [DEPTH-1:0]            match_vec;
    logic [IW-1:0]               match_idx;
    logic [IW-1:0]               rank_m;
    logic                        full;
    logic [DEPTH-1:0]            evict_vec;
    logic [IW-1:0]               ins_idx;
    logic                        hit_now;
    logic [32:0]                 exp_sum;
    logic [31:0]                 expiry_new;
    logic [IW-1:0]               wr_idx;

    always_comb
    begin
        match_idx = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            match_vec[i] = valid_reg[i] && (key_cell_reg[i] == key_reg);
            if (match_vec[i])
            begin
                match_idx = match_idx | IW'(i);
            end
        end
    end

    always_comb
    begin
        rank_m  = '0;
        ins_idx = '0;
        full    = CW'(entries_reg) >= CW'(limit);
        for (int i = 0; i < DEPTH; i++)
        begin
            if (match_vec_reg[i])
            begin
                rank_m = rank_m | rank_reg[i];
            end
            evict_vec[i] = full && valid_reg[i]
                           && (CW'(rank_reg[i]) == CW'(entries_reg) - CW'(1));
        end
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i] || evict_vec[i])
            begin
                ins_idx = IW'(i);
            end
        end
    end

    assign hit_now    = match_any_reg && (now_reg < expiry_rd_reg);
    assign exp_sum    = {1'b0, now_reg} + 33'(ttl);
    assign expiry_new = exp_sum[32] ? '1 : exp_sum[31:0];
    assign wr_idx     = match_any_reg ? match_idx_reg : ins_idx_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg    <= cmd;
            now_reg    <= now_sec;
            key_reg    <= key;
            handle_reg <= handle;
        end
        if (ctl.read)
        begin
            rank_m_reg    <= rank_m;
            evict_vec_reg <= evict_vec;
            ins_idx_reg   <= ins_idx;
            full_reg      <= full;
            value_rd_reg  <= value_mem[match_idx_reg];
            expiry_rd_reg <= expiry_mem[match_idx_reg];
        end
        if (ctl.exec)
        begin
            hit_reg       <= (cmd_reg == lttl_pkg::CMD_GET) && hit_now;
            value_out_reg <= ((cmd_reg == lttl_pkg::CMD_GET) && hit_now) ? value_rd_reg : '0;
            if (cmd_reg == lttl_pkg::CMD_PUT)
            begin
                value_mem[wr_idx]  <= handle_reg;
                expiry_mem[wr_idx] <= expiry_new;
                if (!match_any_reg)
                begin
                    key_cell_reg[ins_idx_reg] <= key_reg;
                end
            end
            for (int i = 0; i < DEPTH; i++)
            begin
                case (cmd_reg)
                    lttl_pkg::CMD_GET:
                    begin
                        if (hit_now)
                        begin
                            if (match_vec_reg[i])
                            begin
                                rank_reg[i] <= '0;
                            end
                            else if (valid_reg[i] && rank_reg[i] < rank_m_reg)
                            begin
                                rank_reg[i] <= rank_reg[i] + IW'(1);
                            end
                        end
                        else if (match_any_reg && valid_reg[i] && rank_reg[i] > rank_m_reg)
                        begin
                            rank_reg[i] <= rank_reg[i] - IW'(1);
                        end
                    end
                    lttl_pkg::CMD_PUT:
                    begin
                        if (match_any_reg)
                        begin
                            if (match_vec_reg[i])
                            begin
                                rank_reg[i] <= '0;
                            end
                            else if (valid_reg[i] && rank_reg[i] < rank_m_reg)
                            begin
                                rank_reg[i] <= rank_reg[i] + IW'(1);
                            end
                        end
                        else if (IW'(i) == ins_idx_reg)
                        begin
                            rank_reg[i] <= '0;
                        end
                        else if (valid_reg[i] && !evict_vec_reg[i])
                        begin
                            rank_reg[i] <= rank_reg[i] + IW'(1);
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            entries_reg   <= '0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            match_vec_reg <= '0;
            match_any_reg <= 1'b0;
            match_idx_reg <= '0;
            count_out_reg <= '0;
        end
        else
        begin
            if (ctl.trim)
            begin
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (valid_reg[i] && CW'(rank_reg[i]) >= CW'(limit))
                    begin
                        valid_reg[i] <= 1'b0;
                    end
                end
                if (entries_reg > limit)
                begin
                    entries_reg <= limit;
                end
            end
            if (ctl.look)
            begin
                match_vec_reg <= match_vec;
                match_any_reg <= |match_vec;
                match_idx_reg <= match_idx;
            end
            if (ctl.exec)
            begin
                case (cmd_reg)
                    lttl_pkg::CMD_GET:
                    begin
                        if (hit_now)
                        begin
                            count_out_reg <= entries_reg;
                            if (hits_reg != TOT_MAX)
                            begin
                                hits_reg <= hits_reg + lttl_pkg::TOT_W'(1);
                            end
                        end
                        else
                        begin
                            if (misses_reg != TOT_MAX)
                            begin
                                misses_reg <= misses_reg + lttl_pkg::TOT_W'(1);
                            end
                            if (match_any_reg)
                            begin
                                valid_reg     <= valid_reg & ~match_vec_reg;
                                entries_reg   <= entries_reg - lttl_pkg::CNT_W'(1);
                                count_out_reg <= entries_reg - lttl_pkg::CNT_W'(1);
                            end
                            else
                            begin
                                count_out_reg <= entries_reg;
                            end
                        end
                    end
                    lttl_pkg::CMD_PUT:
                    begin
                        if (!match_any_reg)
                        begin
                            for (int i = 0; i < DEPTH; i++)
                            begin
                                if (IW'(i) == ins_idx_reg)
                                begin
                                    valid_reg[i] <= 1'b1;
                                end
                                else if (evict_vec_reg[i])
                                begin
                                    valid_reg[i] <= 1'b0;
                                end
                            end
                            if (!full_reg)
                            begin
                                entries_reg   <= entries_reg + lttl_pkg::CNT_W'(1);
                                count_out_reg <= entries_reg + lttl_pkg::CNT_W'(1);
                            end
                            else
                            begin
                                count_out_reg <= entries_reg;
                            end
                        end
                        else
                        begin
                            count_out_reg <= entries_reg;
                        end
                    end
                    lttl_pkg::CMD_CLEAR:
                    begin
                        valid_reg     <= '0;
                        entries_reg   <= '0;
                        count_out_reg <= '0;
                    end
                    default: count_out_reg <= entries_reg;
                endcase
            end
        end
    end

    assign hit         = hit_reg;
    assign value_out   = value_out_reg;
    assign hit_total   = hits_reg;
    assign miss_total  = misses_reg;
    assign entry_count = count_out_reg;

`ifndef SYNTHESIS
    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        32'(entries_reg) == $countones(valid_reg))
        else $error("entry count differs from valid entries");
    a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_vec_reg))
        else $error("more than one entry matched");
`endif

endmodule

### sv/lru_ttl_lookup_cache_unit.sv
// LRU lookup cache with per-entry time-to-live.
// Channels: req (sink) carries cmd, now_sec and the key fields latitude_q,
// longitude_q, forecast_kind, day_offset plus value_handle; rsp (source)
// returns hit, value_out, hit_total, miss_total and entry_count. A transfer
// happens when valid and ready are both high. Every request yields one
// response.
// Registers on the APB port: ttl_seconds at 0x0, entry limit at 0x4. Write
// them only while no request is in flight. Lowering the entry limit evicts
// least recent entries in the cycle after the write.
// Steps: the response is registered after trim, tag compare over all entries,
// memory read and update, in that order. A new request is taken only once
// the previous one has finished its update step.
// A result waiting on rsp does not block the next request; the update step
// of that next request waits until the pending result is taken.
// Reset empties the table, zeroes the counters and loads ttl 1800 and
// entry limit 100. Key and data storage are not cleared.
module lru_ttl_lookup_cache_unit #(
    parameter int DEPTH = 128
) (
    input  logic         clk,
    input  logic         rst_n,
    lttl_req_if.sink     req,
    lttl_rsp_if.source   rsp,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [lttl_pkg::TTL_W-1:0] ttl_reg;
    logic [lttl_pkg::CNT_W-1:0] max_reg;
    logic [lttl_pkg::CNT_W-1:0] limit;
    lttl_pkg::ctl_t             ctl;
    logic                       wr_en;
    logic                       trim_req_reg;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ttl_reg      <= lttl_pkg::TTL_RESET;
            max_reg      <= lttl_pkg::MAX_RESET;
            trim_req_reg <= 1'b0;
        end
        else
        begin
            trim_req_reg <= wr_en && (paddr[2] == lttl_pkg::REG_MAX);
            if (wr_en)
            begin
                unique case (paddr[2])
                    lttl_pkg::REG_TTL: ttl_reg <= pwdata[lttl_pkg::TTL_W-1:0];
                    lttl_pkg::REG_MAX: max_reg <= pwdata[lttl_pkg::CNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign prdata = (paddr[2] == lttl_pkg::REG_MAX) ? 32'(max_reg) : 32'(ttl_reg);

    always_comb
    begin
        if (max_reg == '0)
        begin
            limit = lttl_pkg::CNT_W'(1);
        end
        else if (32'(max_reg) > DEPTH)
        begin
            limit = lttl_pkg::CNT_W'(DEPTH);
        end
        else
        begin
            limit = max_reg;
        end
    end

    lttl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .trim_req  (trim_req_reg),
        .ctl       (ctl)
    );

    lttl_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .cmd         (req.cmd),
        .now_sec     (req.now_sec),
        .key         ({req.latitude_q, req.longitude_q, req.forecast_kind, req.day_offset}),
        .handle      (req.value_handle),
        .ttl         (ttl_reg),
        .limit       (limit),
        .hit         (rsp.hit),
        .value_out   (rsp.value_out),
        .hit_total   (rsp.hit_total),
        .miss_total  (rsp.miss_total),
        .entry_count (rsp.entry_count)
    );

`ifndef SYNTHESIS
    a_limit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (limit != '0) && (32'(limit) <= DEPTH))
        else $error("effective entry limit out of range");
`endif

endmodule

### dv/lttl_check.sv
`timescale 1ns / 1ps

module lttl_check (
    input  logic       clk,
    input  logic       rst_n,
    lttl_req_if.sink   req_mon,
    lttl_rsp_if.sink   rsp_mon,
    input  logic       cfg_we,
    input  logic       cfg_sel,
    input  logic [31:0] cfg_data,
    output int         fail_count,
    output int         pending_results
);

    localparam int DEPTH = 128;
    localparam logic [lttl_pkg::TOT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic                        hit;
        logic [31:0]                 value_out;
        logic [lttl_pkg::TOT_W-1:0]  hit_total;
        logic [lttl_pkg::TOT_W-1:0]  miss_total;
        logic [lttl_pkg::CNT_W-1:0]  entry_count;
    } lookup_result_t;

    logic [lttl_pkg::KEY_W-1:0]  tags [DEPTH];
    logic [31:0]                 handles [DEPTH];
    logic [31:0]                 expiry [DEPTH];
    logic                        live [DEPTH];
    int                          rank [DEPTH];
    int                          used;
    logic [lttl_pkg::TOT_W-1:0]  hits;
    logic [lttl_pkg::TOT_W-1:0]  misses;
    logic [lttl_pkg::TTL_W-1:0]  ttl;
    logic [lttl_pkg::CNT_W-1:0]  max_cfg;
    lookup_result_t              lookup_results [$];

    assign pending_results = lookup_results.size();

    function automatic int cap();
        int m;
        m = max_cfg;
        if (m == 0) m = 1;
        if (m > DEPTH) m = DEPTH;
        return m;
    endfunction

    function automatic void drop(int s);
        int r;
        r = rank[s];
        live[s] = 1'b0;
        for (int i = 0; i < DEPTH; i++)
            if (live[i] && rank[i] > r) rank[i]--;
        if (used > 0) used--;
    endfunction

    function automatic void drop_oldest();
        if (used == 0) return;
        for (int i = 0; i < DEPTH; i++)
            if (live[i] && rank[i] == used - 1)
            begin
                drop(i);
                return;
            end
    endfunction

    function automatic void promote(int s);
        int r;
        r = rank[s];
        for (int i = 0; i < DEPTH; i++)
            if (live[i] && rank[i] < r) rank[i]++;
        rank[s] = 0;
    endfunction

    function automatic int lookup(logic [lttl_pkg::KEY_W-1:0] k);
        for (int i = 0; i < DEPTH; i++)
            if (live[i] && tags[i] == k) return i;
        return -1;
    endfunction

    function automatic logic [31:0] stamp(logic [31:0] now);
        logic [32:0] e;
        e = {1'b0, now} + 33'(ttl);
        return e[32] ? 32'hFFFF_FFFF : e[31:0];
    endfunction

    function automatic void trim();
        while (used > cap()) drop_oldest();
    endfunction

    function automatic lookup_result_t serve(lttl_pkg::cmd_t c, logic [31:0] now,
                                             logic [lttl_pkg::KEY_W-1:0] k,
                                             logic [31:0] h);
        lookup_result_t res;
        int s;
        res = '0;
        trim();
        if (c == lttl_pkg::CMD_GET)
        begin
            s = lookup(k);
            if (s >= 0 && now < expiry[s])
            begin
                promote(s);
                res.hit = 1'b1;
                res.value_out = handles[s];
                if (hits != CNT_MAX) hits++;
            end
            else
            begin
                if (s >= 0) drop(s);
                if (misses != CNT_MAX) misses++;
            end
        end
        else if (c == lttl_pkg::CMD_PUT)
        begin
            s = lookup(k);
            if (s >= 0)
            begin
                handles[s] = h;
                expiry[s] = stamp(now);
                promote(s);
            end
            else
            begin
                if (used >= cap()) drop_oldest();
                for (int i = 0; i < DEPTH; i++)
                    if (live[i]) rank[i]++;
                for (int i = 0; i < DEPTH; i++)
                    if (!live[i])
                    begin
                        live[i] = 1'b1;
                        tags[i] = k;
                        handles[i] = h;
                        expiry[i] = stamp(now);
                        rank[i] = 0;
                        used++;
                        break;
                    end
            end
        end
        else if (c == lttl_pkg::CMD_CLEAR)
        begin
            for (int i = 0; i < DEPTH; i++) live[i] = 1'b0;
            used = 0;
        end
        res.hit_total = hits;
        res.miss_total = misses;
        res.entry_count = lttl_pkg::CNT_W'(used);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lookup_result_t want;
        lookup_result_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++) live[i] = 1'b0;
            used = 0;
            hits = '0;
            misses = '0;
            ttl = lttl_pkg::TTL_RESET;
            max_cfg = lttl_pkg::MAX_RESET;
            lookup_results.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_sel == lttl_pkg::REG_TTL) ttl = cfg_data[lttl_pkg::TTL_W-1:0];
                else
                begin
                    max_cfg = cfg_data[lttl_pkg::CNT_W-1:0];
                    trim();
                end
            end
            if (rsp_mon.valid && rsp_mon.ready)
            begin
                got = '{rsp_mon.hit, rsp_mon.value_out, rsp_mon.hit_total,
                        rsp_mon.miss_total, rsp_mon.entry_count};
                if (lookup_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10) $display("unexpected result %p", got);
                end
                else
                begin
                    want = lookup_results.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
            if (req_mon.valid && req_mon.ready)
                lookup_results.push_back(serve(req_mon.cmd, req_mon.now_sec,
                    {req_mon.latitude_q, req_mon.longitude_q, req_mon.forecast_kind,
                     req_mon.day_offset}, req_mon.value_handle));
        end
    end
endmodule

### dv/lru_ttl_lookup_cache_unit_test.sv
`timescale 1ns / 1ps

module lru_ttl_lookup_cache_unit_test;

    localparam int IDLE_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending_results;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_off;
    int          quiet_cycles;

    lttl_req_if req ();
    lttl_rsp_if rsp ();

    lru_ttl_lookup_cache_unit DUT (
        .clk(clk), .rst_n(rst_n), .req(req.sink), .rsp(rsp.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    lttl_check checker_i (
        .clk(clk), .rst_n(rst_n), .req_mon(req.sink), .rsp_mon(rsp.sink),
        .cfg_we(psel && penable && pwrite && pready), .cfg_sel(paddr[2]),
        .cfg_data(pwdata), .fail_count(fail_count), .pending_results(pending_results)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        if (hold_off) rsp.ready <= 1'b0;
        else rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(logic reg_sel, logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain();
        while (pending_results != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic send(lttl_pkg::cmd_t c, logic [31:0] now, logic [20:0] lat,
                        logic [21:0] lon, logic [3:0] kind, logic [3:0] days,
                        logic [31:0] h);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.cmd <= c;
        req.now_sec <= now;
        req.latitude_q <= lat;
        req.longitude_q <= lon;
        req.forecast_kind <= kind;
        req.day_offset <= days;
        req.value_handle <= h;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
    endtask

    task automatic finish_burst();
        req.valid <= 1'b0;
        @(posedge clk);
    endtask

    // random items over a small key pool so that hits, refreshes and expiry happen
    task automatic random_items(int n, int pool);
        logic [31:0] now;
        int r;
        int k;
        now = $urandom_range(50000);
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            k = $urandom_range(pool - 1);
            now = now + $urandom_range(400);
            if (r < 3) send(lttl_pkg::CMD_CLEAR, now, 21'($urandom), 22'($urandom),
                            4'($urandom), 4'($urandom), $urandom);
            else if (r < 8) send(lttl_pkg::CMD_STATS, $urandom, 21'($urandom),
                                 22'($urandom), 4'($urandom), 4'($urandom), $urandom);
            else if (r < 15) send(r[0] ? lttl_pkg::CMD_GET : lttl_pkg::CMD_PUT, $urandom,
                                  21'($urandom), 22'($urandom), 4'($urandom),
                                  4'($urandom), $urandom);
            else send(r < 55 ? lttl_pkg::CMD_GET : lttl_pkg::CMD_PUT, now,
                      21'(k * 7919 - 900000), 22'(1800000 - k * 104729), 4'(k),
                      4'(k >> 4), $urandom);
        end
        finish_burst();
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req.valid = 1'b0;
        req.cmd = lttl_pkg::CMD_GET;
        req.now_sec = '0;
        req.latitude_q = '0;
        req.longitude_q = '0;
        req.forecast_kind = '0;
        req.day_offset = '0;
        req.value_handle = '0;
        rsp.ready = 1'b0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every command, expiry edge, saturated expiry, refresh
        send(lttl_pkg::CMD_GET, '0, 21'sd900000, 22'sd1800000, 4'hF, 4'hF, '1);
        send(lttl_pkg::CMD_PUT, 32'd100, 21'sd900000, 22'sd1800000, 4'hF, 4'hF,
             32'hFFFF_FFFF);
        send(lttl_pkg::CMD_GET, 32'd1899, 21'sd900000, 22'sd1800000, 4'hF, 4'hF, '0);
        send(lttl_pkg::CMD_GET, 32'd1900, 21'sd900000, 22'sd1800000, 4'hF, 4'hF, '0);
        send(lttl_pkg::CMD_PUT, 32'hFFFF_FFF0, -21'sd900000, -22'sd1800000, 4'h0, 4'h0,
             32'h1234);
        send(lttl_pkg::CMD_GET, 32'hFFFF_FFFE, -21'sd900000, -22'sd1800000, 4'h0, 4'h0,
             '0);
        send(lttl_pkg::CMD_GET, 32'hFFFF_FFFF, -21'sd900000, -22'sd1800000, 4'h0, 4'h0,
             '0);
        send(lttl_pkg::CMD_PUT, 32'd5, 21'sd1, 22'sd1, 4'h1, 4'h1, 32'hA);
        send(lttl_pkg::CMD_PUT, 32'd9000, 21'sd1, 22'sd1, 4'h1, 4'h1, 32'hB);
        send(lttl_pkg::CMD_GET, 32'd9001, 21'sd1, 22'sd1, 4'h1, 4'h1, '0);
        send(lttl_pkg::CMD_STATS, '1, 21'h1FFFFF, 22'h3FFFFF, 4'hF, 4'hF, '1);
        send(lttl_pkg::CMD_CLEAR, '0, '0, '0, '0, '0, '0);
        send(lttl_pkg::CMD_GET, 32'd9002, 21'sd1, 22'sd1, 4'h1, 4'h1, '0);
        finish_burst();
        drain();

        // limit of one with zero lifetime, then lowering the limit with a full table
        write_reg(lttl_pkg::REG_TTL, 32'd0);
        write_reg(lttl_pkg::REG_MAX, 32'd0);
        random_items(40, 4);
        drain();
        write_reg(lttl_pkg::REG_TTL, 32'hFFFFF);
        write_reg(lttl_pkg::REG_MAX, 32'd128);
        random_items(200, 160);
        drain();
        write_reg(lttl_pkg::REG_MAX, 32'd3);
        write_reg(lttl_pkg::REG_MAX, 32'd255);
        write_reg(lttl_pkg::REG_TTL, 32'd600);

        send_idle_pct = 32;
        recv_idle_pct = 50;
        random_items(450, 140);
        send_idle_pct = 50;
        recv_idle_pct = 32;
        random_items(450, 40);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            random_items(40, 20);
        join
        drain();
        write_reg(lttl_pkg::REG_MAX, 32'd17);
        write_reg(lttl_pkg::REG_TTL, 32'd1800);
        random_items(550, 30);

        while (pending_results != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

### files.f
sv/lttl_pkg.sv
sv/lttl_ifs.sv
sv/lttl_ctrl.sv
sv/lttl_dp.sv
sv/lru_ttl_lookup_cache_unit.sv
dv/lttl_check.sv
dv/lru_ttl_lookup_cache_unit_test.sv
